// ----- hw/rtl/cle_pkg.sv -----
// Shared types and constants for the console line editor.
package cle_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned POS_W   = 6;
	localparam int unsigned START_W = 7;

	localparam logic [BYTE_W-1:0] KEY_DELETE = 8'd127;
	localparam logic [BYTE_W-1:0] KEY_CLEAR  = 8'd3;
	localparam logic [BYTE_W-1:0] KEY_CR     = 8'd13;
	localparam logic [BYTE_W-1:0] KEY_LF     = 8'd10;
	localparam logic [BYTE_W-1:0] KEY_SPACE  = 8'd32;
	localparam logic [BYTE_W-1:0] KEY_SEP    = 8'd0;
	localparam logic [BYTE_W-1:0] CASE_BIT   = 8'd32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_HOLD
	} state_t;

endpackage

// ----- hw/rtl/cle_line_mem.sv -----
// Line store: single-port-write, registered-read byte memory.
module cle_line_mem #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [$clog2(DEPTH)-1:0]            waddr,
	input  logic [cle_pkg::BYTE_W-1:0]          wdata,
	input  logic [$clog2(DEPTH)-1:0]            raddr,
	output logic [cle_pkg::BYTE_W-1:0]          rdata
);

	logic [cle_pkg::BYTE_W-1:0] mem_q [DEPTH];
	logic [cle_pkg::BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/cle_ctrl.sv -----
// Line editing control, length and argument mark registers, and line emit sequencer.
module cle_ctrl #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [cle_pkg::BYTE_W-1:0]        rx_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [cle_pkg::BYTE_W-1:0]        line_char,
	output logic [cle_pkg::POS_W-1:0]         char_position,
	output logic [cle_pkg::START_W-1:0]       arg_start,
	output logic                              last,
	output logic                              mem_we,
	output logic [$clog2(DEPTH)-1:0]          mem_waddr,
	output logic [cle_pkg::BYTE_W-1:0]        mem_wdata,
	output logic [$clog2(DEPTH)-1:0]          mem_raddr,
	input  logic [cle_pkg::BYTE_W-1:0]        mem_rdata
);

	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned LEN_W  = $clog2(DEPTH + 1);

	cle_pkg::state_t state_q, state_next;

	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  mark_q;
	logic [ADDR_W-1:0] idx_q;
	logic [LEN_W-1:0]  emit_len_q;
	logic [LEN_W-1:0]  emit_start_q;

	logic [cle_pkg::BYTE_W-1:0]  line_char_q;
	logic [cle_pkg::POS_W-1:0]   char_position_q;
	logic [cle_pkg::START_W-1:0] arg_start_q;
	logic                        last_q;

	logic [cle_pkg::BYTE_W-1:0] byte_f;
	logic is_alnum, is_space, is_eol, is_del, is_clr;
	logic in_acc, out_acc, room, len_nz, mark_nz, start_emit, fetch_last;

	always_comb begin
		byte_f = rx_byte;
		if (rx_byte >= 8'h41 && rx_byte <= 8'h5A) begin
			byte_f = rx_byte + cle_pkg::CASE_BIT;
		end
	end

	assign is_alnum = (byte_f >= 8'h61 && byte_f <= 8'h7A) || (byte_f >= 8'h30 && byte_f <= 8'h39);
	assign is_space = (byte_f == cle_pkg::KEY_SPACE);
	assign is_eol   = (byte_f == cle_pkg::KEY_CR) || (byte_f == cle_pkg::KEY_LF);
	assign is_del   = (byte_f == cle_pkg::KEY_DELETE);
	assign is_clr   = (byte_f == cle_pkg::KEY_CLEAR);

	assign in_acc     = in_valid && (state_q == cle_pkg::ST_IDLE);
	assign out_acc    = out_valid && !out_stall;
	assign room       = (len_q < LEN_W'(DEPTH));
	assign len_nz     = (len_q != '0);
	assign mark_nz    = (mark_q != '0);
	assign start_emit = in_acc && is_eol && len_nz;
	assign fetch_last = ((LEN_W'(idx_q) + LEN_W'(1)) == emit_len_q);

	assign mem_we    = in_acc && room && (is_alnum || (is_space && len_nz));
	assign mem_waddr = len_q[ADDR_W-1:0];
	assign mem_wdata = is_alnum ? byte_f : (mark_nz ? cle_pkg::KEY_SPACE : cle_pkg::KEY_SEP);

	always_comb begin
		state_next = state_q;
		case (state_q)
			cle_pkg::ST_IDLE: begin
				if (start_emit) begin
					state_next = cle_pkg::ST_FETCH;
				end
			end
			cle_pkg::ST_FETCH: begin
				state_next = cle_pkg::ST_HOLD;
			end
			cle_pkg::ST_HOLD: begin
				if (out_acc) begin
					state_next = last_q ? cle_pkg::ST_IDLE : cle_pkg::ST_FETCH;
				end
			end
			default: begin
				state_next = cle_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		mem_raddr = idx_q;
		case (state_q)
			cle_pkg::ST_IDLE: begin
				in_stall  = 1'b0;
				mem_raddr = '0;
			end
			cle_pkg::ST_FETCH: begin
				mem_raddr = idx_q;
			end
			cle_pkg::ST_HOLD: begin
				out_valid = 1'b1;
				mem_raddr = idx_q + ADDR_W'(1);
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cle_pkg::ST_IDLE;
			len_q   <= '0;
			mark_q  <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_next;
			if (start_emit) begin
				idx_q <= '0;
			end else if (state_q == cle_pkg::ST_HOLD && out_acc && !last_q) begin
				idx_q <= idx_q + ADDR_W'(1);
			end
			if (in_acc) begin
				if (mem_we) begin
					len_q <= len_q + LEN_W'(1);
					if (is_space && !mark_nz) begin
						mark_q <= len_q + LEN_W'(1);
					end
				end else if (is_eol || is_clr) begin
					len_q  <= '0;
					mark_q <= '0;
				end else if (is_del && len_nz) begin
					len_q <= len_q - LEN_W'(1);
					if (mark_nz && len_q == mark_q) begin
						mark_q <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_emit) begin
			emit_len_q   <= len_q;
			emit_start_q <= mark_nz ? mark_q : len_q;
		end
		if (state_q == cle_pkg::ST_FETCH) begin
			line_char_q     <= mem_rdata;
			char_position_q <= cle_pkg::POS_W'(idx_q);
			arg_start_q     <= cle_pkg::START_W'(emit_start_q);
			last_q          <= fetch_last;
		end
	end

	assign line_char     = line_char_q;
	assign char_position = char_position_q;
	assign arg_start     = arg_start_q;
	assign last          = last_q;

endmodule

// ----- hw/rtl/console_line_editor.sv -----
// Console line editor top level: line store memory and editing control.
// Received bytes edit a command line held in a LINE_DEPTH-byte store. A
// carriage return or line feed on a non-empty line emits the stored bytes in
// order, one word per stored byte; each result word passes through the
// memory read and then the output register, and is held while out_stall
// is high. While a line is being emitted the input is stalled, and after the
// last result word is taken the next input word may be accepted in the
// following cycle.
module console_line_editor #(
	parameter int unsigned LINE_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [cle_pkg::BYTE_W-1:0]  rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [cle_pkg::BYTE_W-1:0]  line_char,
	output logic [cle_pkg::POS_W-1:0]   char_position,
	output logic [cle_pkg::START_W-1:0] arg_start,
	output logic                        last
);

	localparam int unsigned ADDR_W = $clog2(LINE_DEPTH);

	logic                       mem_we;
	logic [ADDR_W-1:0]          mem_waddr;
	logic [cle_pkg::BYTE_W-1:0] mem_wdata;
	logic [ADDR_W-1:0]          mem_raddr;
	logic [cle_pkg::BYTE_W-1:0] mem_rdata;

	cle_ctrl #(
		.DEPTH(LINE_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.line_char    (line_char),
		.char_position(char_position),
		.arg_start    (arg_start),
		.last         (last),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	cle_line_mem #(
		.DEPTH(LINE_DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

// ----- hw/rtl/cle_checker.sv -----
// Port-level checker for the console line editor and its bind statement.
module cle_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [cle_pkg::BYTE_W-1:0]  rx_byte,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [cle_pkg::BYTE_W-1:0]  line_char,
	input logic [cle_pkg::POS_W-1:0]   char_position,
	input logic [cle_pkg::START_W-1:0] arg_start,
	input logic                        last
);

	logic out_acc;
	assign out_acc = out_valid && !out_stall;

	a_no_input_during_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while a result word is pending");

	a_input_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(rx_byte))
		else $error("stalled input word changed");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(line_char) && $stable(last))
		else $error("stalled result word changed");

	a_end_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && last |=> !out_valid)
		else $error("result word follows the last word of a line");

	a_position_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !last |=> ##1 (out_valid
			&& char_position == $past(char_position, 2) + cle_pkg::POS_W'(1)
			&& arg_start == $past(arg_start, 2)))
		else $error("line position or argument start broke within a line");

endmodule

bind console_line_editor cle_checker u_cle_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.rx_byte      (rx_byte),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.line_char    (line_char),
	.char_position(char_position),
	.arg_start    (arg_start),
	.last         (last)
);
